>>> rtl/core/zcsq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zcsq_pkg: shared types and constants of the zero-cross sync qualifier
// Request payloads, register map, reset values and divider sizing.
// ----------------------------------------------------------------------------
package zcsq_pkg;

	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned QUO_W   = 23;
	localparam int unsigned DIV_W   = 16;
	localparam int unsigned STEP_W  = 5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLANKING = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_MIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_MAX = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd3;

	localparam logic [CFG_W-1:0] BLANKING_RST = 16'd5000;
	localparam logic [CFG_W-1:0] HALF_MIN_RST = 16'd7000;
	localparam logic [CFG_W-1:0] HALF_MAX_RST = 16'd12500;
	localparam logic [CFG_W-1:0] TIMEOUT_RST  = 16'd30;

	// frequency x10 = FREQ_NUM / half period
	localparam logic [QUO_W-1:0] FREQ_NUM = 23'd5000000;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUO_W - 1);

	// request commands
	localparam logic CMD_EDGE   = 1'b0;
	localparam logic CMD_UPDATE = 1'b1;

	typedef struct packed {
		logic        command;
		logic [15:0] capture_us;
		logic [31:0] time_ms;
	} in_item_t;

	typedef struct packed {
		logic        zero_cross;
		logic        present;
		logic [15:0] half_period_us;
		logic [31:0] pulse_count;
		logic [31:0] glitch_count;
		logic [22:0] frequency_x10;
	} out_item_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             valid;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

endpackage : zcsq_pkg
`default_nettype wire

>>> rtl/core/zcsq_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zcsq_div: iterative constant-by-divisor divider
// Restoring division of FREQ_NUM by a 16-bit divisor, one quotient bit per
// cycle through a single shared subtract and compare.
// ----------------------------------------------------------------------------
module zcsq_div (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire zcsq_pkg::div_req_t req,
	output zcsq_pkg::div_rsp_t      rsp
);
	import zcsq_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dvsr_q;
	logic [QUO_W-1:0]  quo_q;

	logic [DIV_W:0] trial;
	logic [DIV_W:0] diff;
	logic           ge;

	// bring down the next dividend bit, MSB first
	assign trial = {rem_q, FREQ_NUM[step_q]};
	assign diff  = trial - {1'b0, dvsr_q};
	assign ge    = (trial >= {1'b0, dvsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= LAST_STEP;
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			dvsr_q <= req.divisor;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign rsp.valid    = done_q;
	assign rsp.quotient = quo_q;

endmodule : zcsq_div
`default_nettype wire

>>> rtl/core/zero_cross_sync_qualifier_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zero_cross_sync_qualifier_unit: mains zero-cross edge qualifier
// Flow: a request is accepted in idle, the bit-serial divider works out the
// frequency, then the result loads into the output register once it is free.
// One request in flight at a time: a new request is taken only after the
// previous result has been loaded.
// Reset: config registers return to their defaults, counters and control clear.
// ----------------------------------------------------------------------------
module zero_cross_sync_qualifier_unit (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire zcsq_pkg::in_item_t             in_data,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output zcsq_pkg::out_item_t                 out_data,
	input  wire                                 cfg_we,
	input  wire [zcsq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [zcsq_pkg::CFG_W-1:0]           cfg_wdata
);
	import zcsq_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_DIV  = 1'b1;

	logic state_q;

	logic [CFG_W-1:0] blanking_q;
	logic [CFG_W-1:0] half_min_q;
	logic [CFG_W-1:0] half_max_q;
	logic [CFG_W-1:0] timeout_q;

	logic [15:0] prev_cap_q;
	logic [15:0] half_q;
	logic [31:0] pulses_q;
	logic [31:0] glitches_q;
	logic        present_q;
	logic [31:0] last_ms_q;
	logic        pulse_q;

	logic        accept;
	logic        load;
	logic [15:0] interval;
	logic        blanked;
	logic        in_window;
	logic [15:0] half_next;
	logic        pulse;
	logic [31:0] elapsed;

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign load     = (state_q == S_DIV) && div_rsp.valid && (!out_valid || out_ready);

	assign interval  = in_data.capture_us - prev_cap_q;
	assign blanked   = (interval < blanking_q);
	assign in_window = (interval >= half_min_q) && (interval <= half_max_q);
	assign elapsed   = in_data.time_ms - last_ms_q;

	always_comb begin
		half_next = half_q;
		pulse     = 1'b0;
		if (in_data.command == CMD_EDGE && !blanked) begin
			if (in_window) begin
				half_next = interval;
			end
			pulse = (half_next != '0);
		end
	end

	assign div_req.start   = accept;
	assign div_req.divisor = half_next;

	zcsq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blanking_q <= BLANKING_RST;
			half_min_q <= HALF_MIN_RST;
			half_max_q <= HALF_MAX_RST;
			timeout_q  <= TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLANKING: blanking_q <= cfg_wdata;
				REG_HALF_MIN: half_min_q <= cfg_wdata;
				REG_HALF_MAX: half_max_q <= cfg_wdata;
				REG_TIMEOUT:  timeout_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			prev_cap_q <= '0;
			half_q     <= '0;
			pulses_q   <= '0;
			glitches_q <= '0;
			present_q  <= 1'b0;
			last_ms_q  <= '0;
			pulse_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DIV;
						pulse_q <= pulse;
						if (in_data.command == CMD_EDGE) begin
							prev_cap_q <= in_data.capture_us;
							half_q     <= half_next;
							if (blanked || !in_window) begin
								glitches_q <= glitches_q + 32'd1;
							end
							if (pulse) begin
								last_ms_q <= in_data.time_ms;
								pulses_q  <= pulses_q + 32'd1;
								present_q <= 1'b1;
							end
						end else if (elapsed > {16'd0, timeout_q}) begin
							// no pulse within the timeout: drop sync
							present_q <= 1'b0;
						end
					end
				end
				S_DIV: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register: hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data.zero_cross     <= pulse_q;
			out_data.present        <= present_q;
			out_data.half_period_us <= half_q;
			out_data.pulse_count    <= pulses_q;
			out_data.glitch_count   <= glitches_q;
			out_data.frequency_x10  <= (half_q == '0) ? '0 : div_rsp.quotient;
		end
	end

endmodule : zero_cross_sync_qualifier_unit
`default_nettype wire
